>>> rtl/core/snrgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SNR grid centroid package
// Shared types, codes and constants of the SNR grid weighted centroid block.
// ----------------------------------------------------------------------------
package snrgc_pkg;

    localparam int GRID_SIDE_DEF = 32;
    localparam int POS_W         = 24;
    localparam int SNR_W         = 16;
    localparam int CFG_W         = 24;
    localparam int CFG_IDX_W     = 2;

    localparam logic [1:0] FUNC_STORE   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR   = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd3;

    localparam logic [15:0] RST_CELL_SIZE = 16'd256;
    localparam logic [15:0] RST_THRESHOLD = 16'd52429;

    localparam int DIV_NW = 64;
    localparam int DIV_DW = 40;

    localparam logic [2:0] DSEL_SX   = 3'd0;
    localparam logic [2:0] DSEL_SY   = 3'd1;
    localparam logic [2:0] DSEL_CX   = 3'd2;
    localparam logic [2:0] DSEL_CY   = 3'd3;
    localparam logic [2:0] DSEL_QUAL = 3'd4;

    localparam int W_BITS    = 17;
    localparam int W_STEPS   = 17;
    localparam int MUL_STEPS = 16;

    typedef struct packed {
        logic [1:0]              func;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [SNR_W-1:0]        snr_value;
    } in_word_t;

    typedef struct packed {
        logic                    in_map;
        logic                    found;
        logic signed [POS_W-1:0] centroid_x;
        logic signed [POS_W-1:0] centroid_y;
        logic [SNR_W-1:0]        quality;
    } out_word_t;

    typedef struct packed {
        logic       latch_in;
        logic       addr_clr;
        logic       addr_inc;
        logic       mem_clr_we;
        logic       mem_store_we;
        logic       max_clr;
        logic       max_upd;
        logic       mx2_load;
        logic       w_init;
        logic       w_step;
        logic       acc_clr;
        logic       acc_upd;
        logic       mul_init;
        logic       mul_step;
        logic       div_start;
        logic [2:0] div_sel;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       addr_last;
        logic       max_zero;
        logic       div_done;
    } status_t;

endpackage
`default_nettype wire

>>> rtl/core/snr_grid_weighted_centroid_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SNR grid weighted centroid
// Grid map of SNR samples with a thresholded, weighted centroid search.
//
// Input words carry an operation (store, clear, compute) with a position and
// an SNR value; each accepted word gives exactly one output word. Both
// channels use valid and stall. The user must make configuration writes
// through cfg_we, cfg_index and cfg_data only while the block is idle; the
// block itself does not enforce it. With N = GRID_SIDE * GRID_SIDE cells, a
// store word runs two divisions for the cell indexes, a clear word writes
// the N cells (one memory write per cycle), and a compute word runs a maximum
// sweep, a weight pass with a one-bit-per-cycle weight division per cell,
// a multiply and three divisions; an empty grid ends it after the sweep.
// Words are taken one at a time.
// After reset the grid is cleared while in_stall is high.
// A finished word waits in the output register while out_stall is high; the
// next input word is accepted meanwhile and is held at its end until the
// register frees up.
// ----------------------------------------------------------------------------
module snr_grid_weighted_centroid_top #(
    parameter int GRID_SIDE = snrgc_pkg::GRID_SIDE_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [snrgc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [snrgc_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire snrgc_pkg::in_word_t               in_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output snrgc_pkg::out_word_t                   out_data
);

    snrgc_pkg::cmd_t    cmd;
    snrgc_pkg::status_t status;

    snrgc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    snrgc_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

>>> rtl/core/snrgc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SNR grid centroid divider
// Restoring unsigned divider that settles one quotient bit per cycle.
// ----------------------------------------------------------------------------
module snrgc_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [snrgc_pkg::DIV_NW-1:0]  dividend,
    input  wire logic [snrgc_pkg::DIV_DW-1:0]  divisor,
    output logic                               done,
    output logic [snrgc_pkg::DIV_NW-1:0]       quotient,
    output logic [snrgc_pkg::DIV_DW-1:0]       remainder
);

    localparam int NW = snrgc_pkg::DIV_NW;
    localparam int DW = snrgc_pkg::DIV_DW;
    localparam int CW = $clog2(NW);

    logic [NW-1:0] q_reg;
    logic [DW-1:0] r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   r_sh;
    logic          ge;
    logic [DW:0]   r_sub;

    always_comb
    begin
        r_sh  = {r_reg, q_reg[NW-1]};
        ge    = r_sh >= {1'b0, d_reg};
        r_sub = ge ? (r_sh - {1'b0, d_reg}) : r_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[NW-2:0], ge};
            r_reg <= r_sub[DW-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule
`default_nettype wire

>>> rtl/core/snrgc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SNR grid centroid datapath
// Grid memory, configuration registers, accumulators and the shared divider.
// ----------------------------------------------------------------------------
module snrgc_datapath #(
    parameter int GRID_SIDE = snrgc_pkg::GRID_SIDE_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [snrgc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [snrgc_pkg::CFG_W-1:0]       cfg_data,
    input  wire snrgc_pkg::in_word_t               in_data,
    input  wire snrgc_pkg::cmd_t                   cmd,
    output snrgc_pkg::status_t                     status,
    output snrgc_pkg::out_word_t                   out_data
);

    localparam int N      = GRID_SIDE * GRID_SIDE;
    localparam int AW     = $clog2(N);
    localparam int IW     = $clog2(GRID_SIDE);
    localparam int OFFSET = (GRID_SIDE + 1) / 2;
    localparam int OFF_W  = IW + 2;
    localparam int PW     = snrgc_pkg::POS_W;
    localparam int SW     = snrgc_pkg::SNR_W;
    localparam int NW     = snrgc_pkg::DIV_NW;
    localparam int DW     = snrgc_pkg::DIV_DW;
    localparam int WB     = snrgc_pkg::W_BITS;
    localparam int SN_W   = 28;
    localparam int BXW    = 42;
    localparam int NUM_W  = 60;
    localparam int WS_W   = 33;
    localparam int QS_W   = 32;
    localparam int CNT_W  = 17;
    localparam int QW     = 26;

    logic signed [PW-1:0] center_x_reg;
    logic signed [PW-1:0] center_y_reg;
    logic [15:0]          cell_size_reg;
    logic [15:0]          thr_reg;
    logic [15:0]          res;

    logic [1:0]           func_reg;
    logic signed [PW-1:0] pos_x_reg;
    logic signed [PW-1:0] pos_y_reg;
    logic [SW-1:0]        snr_reg;

    logic [AW-1:0]        addr_reg;
    logic [IW-1:0]        i_reg;
    logic [IW-1:0]        j_reg;
    logic [SW-1:0]        mem [N];
    logic [SW-1:0]        rd_data_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [SW-1:0]        mem_wdata;

    logic                 sx_ok_reg;
    logic                 sy_ok_reg;
    logic [IW-1:0]        sx_idx_reg;
    logic [IW-1:0]        sy_idx_reg;
    logic                 in_map_reg;

    logic [SW-1:0]        max_reg;
    logic [2*SW-1:0]      mx2_reg;
    logic [SW-1:0]        s_reg;
    logic [2*SW:0]        w_rem_reg;
    logic [WB-1:0]        wq_reg;
    logic                 w_ge;
    logic [2*SW:0]        w_sub;

    logic signed [BXW-1:0]   bx_reg;
    logic signed [BXW-1:0]   by_reg;
    logic [WS_W-1:0]         wsum_reg;
    logic [QS_W-1:0]         qsum_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [OFF_W-1:0] off_i;
    logic signed [OFF_W-1:0] off_j;
    logic signed [WB+OFF_W:0] prod_x;
    logic signed [WB+OFF_W:0] prod_y;
    logic                    selected;

    logic signed [NUM_W-1:0] mcx_reg;
    logic signed [NUM_W-1:0] mcy_reg;
    logic signed [NUM_W-1:0] px_reg;
    logic signed [NUM_W-1:0] py_reg;
    logic [15:0]             res_sh_reg;

    logic signed [PW-1:0]    cx_reg;
    logic signed [PW-1:0]    cy_reg;
    logic [SW-1:0]           quality_reg;

    logic [SN_W-1:0]         span;
    logic signed [SN_W-1:0]  snx;
    logic signed [SN_W-1:0]  sny;
    logic signed [NUM_W-1:0] ncx;
    logic signed [NUM_W-1:0] ncy;
    logic [NW-1:0]           div_dividend;
    logic [DW-1:0]           div_divisor;
    logic                    div_neg;
    logic                    div_done;
    logic [NW-1:0]           div_quo;
    logic [DW-1:0]           div_rem;
    logic [2:0]              sel_reg;
    logic                    neg_reg;
    logic [QW-1:0]           fq_mag;
    logic signed [QW-1:0]    fq;
    logic                    idx_ok;
    snrgc_pkg::out_word_t    out_next;

    function automatic logic [SN_W-1:0] mag_sn(input logic signed [SN_W-1:0] v);
        return v[SN_W-1] ? SN_W'(-v) : SN_W'(v);
    endfunction

    function automatic logic [NUM_W-1:0] mag_num(input logic signed [NUM_W-1:0] v);
        return v[NUM_W-1] ? NUM_W'(-v) : NUM_W'(v);
    endfunction

    function automatic logic signed [PW-1:0] sat_pos(
        input logic signed [PW-1:0] c,
        input logic signed [QW-1:0] d
    );
        logic signed [QW:0] s;
        s = (QW+1)'(c) + (QW+1)'(d);
        if (s[QW:PW-1] != {(QW-PW+2){s[QW]}})
            return s[QW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        return s[PW-1:0];
    endfunction

    assign res = (cell_size_reg == 16'd0) ? 16'd1 : cell_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            cell_size_reg <= snrgc_pkg::RST_CELL_SIZE;
            thr_reg       <= snrgc_pkg::RST_THRESHOLD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                snrgc_pkg::CFG_CENTER_X:  center_x_reg  <= cfg_data;
                snrgc_pkg::CFG_CENTER_Y:  center_y_reg  <= cfg_data;
                snrgc_pkg::CFG_CELL_SIZE: cell_size_reg <= cfg_data[15:0];
                snrgc_pkg::CFG_THRESHOLD: thr_reg       <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            func_reg  <= in_data.func;
            pos_x_reg <= in_data.pos_x;
            pos_y_reg <= in_data.pos_y;
            snr_reg   <= in_data.snr_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            i_reg    <= '0;
            j_reg    <= '0;
        end
        else if (cmd.addr_clr)
        begin
            addr_reg <= '0;
            i_reg    <= '0;
            j_reg    <= '0;
        end
        else if (cmd.addr_inc)
        begin
            addr_reg <= addr_reg + 1'b1;
            if (j_reg == IW'(GRID_SIDE - 1))
            begin
                j_reg <= '0;
                i_reg <= i_reg + 1'b1;
            end
            else
            begin
                j_reg <= j_reg + 1'b1;
            end
        end
    end

    assign idx_ok    = sx_ok_reg && sy_ok_reg;
    assign mem_we    = cmd.mem_clr_we || (cmd.mem_store_we && idx_ok);
    assign mem_waddr = cmd.mem_store_we
                     ? AW'(AW'(sx_idx_reg) * AW'(GRID_SIDE) + AW'(sy_idx_reg))
                     : addr_reg;
    assign mem_wdata = cmd.mem_store_we ? snr_reg : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_store_we)
            in_map_reg <= idx_ok;
        if (cmd.max_clr)
            max_reg <= '0;
        else if (cmd.max_upd && (rd_data_reg > max_reg))
            max_reg <= rd_data_reg;
        if (cmd.mx2_load)
            mx2_reg <= max_reg * max_reg;
    end

    always_comb
    begin
        w_ge  = w_rem_reg >= {1'b0, mx2_reg};
        w_sub = w_ge ? (w_rem_reg - {1'b0, mx2_reg}) : w_rem_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.w_init)
        begin
            s_reg     <= rd_data_reg;
            w_rem_reg <= {1'b0, (2*SW)'(rd_data_reg) * (2*SW)'(rd_data_reg)};
            wq_reg    <= '0;
        end
        else if (cmd.w_step)
        begin
            w_rem_reg <= {w_sub[2*SW-1:0], 1'b0};
            wq_reg    <= {wq_reg[WB-2:0], w_ge};
        end
    end

    always_comb
    begin
        off_i    = $signed(OFF_W'(i_reg)) - $signed(OFF_W'(OFFSET));
        off_j    = $signed(OFF_W'(j_reg)) - $signed(OFF_W'(OFFSET));
        prod_x   = $signed({1'b0, wq_reg}) * off_i;
        prod_y   = $signed({1'b0, wq_reg}) * off_j;
        selected = wq_reg > {1'b0, thr_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clr)
        begin
            bx_reg   <= '0;
            by_reg   <= '0;
            wsum_reg <= '0;
            qsum_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.acc_upd && selected)
        begin
            bx_reg   <= bx_reg + BXW'(prod_x);
            by_reg   <= by_reg + BXW'(prod_y);
            wsum_reg <= wsum_reg + WS_W'(wq_reg);
            qsum_reg <= qsum_reg + QS_W'(s_reg);
            cnt_reg  <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_init)
        begin
            mcx_reg    <= NUM_W'(bx_reg);
            mcy_reg    <= NUM_W'(by_reg);
            px_reg     <= '0;
            py_reg     <= '0;
            res_sh_reg <= res;
        end
        else if (cmd.mul_step)
        begin
            if (res_sh_reg[0])
            begin
                px_reg <= px_reg + mcx_reg;
                py_reg <= py_reg + mcy_reg;
            end
            mcx_reg    <= mcx_reg <<< 1;
            mcy_reg    <= mcy_reg <<< 1;
            res_sh_reg <= res_sh_reg >> 1;
        end
    end

    always_comb
    begin
        span = SN_W'(res) * SN_W'(GRID_SIDE + 1);
        snx  = ((SN_W'(pos_x_reg) - SN_W'(center_x_reg)) <<< 1) + $signed(span);
        sny  = ((SN_W'(pos_y_reg) - SN_W'(center_y_reg)) <<< 1) + $signed(span);
        ncx  = (px_reg <<< 1) + $signed(NUM_W'(wsum_reg));
        ncy  = (py_reg <<< 1) + $signed(NUM_W'(wsum_reg));
        unique case (cmd.div_sel)
            snrgc_pkg::DSEL_SX:
            begin
                div_dividend = NW'(mag_sn(snx));
                div_divisor  = DW'({res, 1'b0});
                div_neg      = snx[SN_W-1];
            end
            snrgc_pkg::DSEL_SY:
            begin
                div_dividend = NW'(mag_sn(sny));
                div_divisor  = DW'({res, 1'b0});
                div_neg      = sny[SN_W-1];
            end
            snrgc_pkg::DSEL_CX:
            begin
                div_dividend = NW'(mag_num(ncx));
                div_divisor  = DW'({wsum_reg, 1'b0});
                div_neg      = ncx[NUM_W-1];
            end
            snrgc_pkg::DSEL_CY:
            begin
                div_dividend = NW'(mag_num(ncy));
                div_divisor  = DW'({wsum_reg, 1'b0});
                div_neg      = ncy[NUM_W-1];
            end
            default:
            begin
                div_dividend = NW'(qsum_reg);
                div_divisor  = DW'(cnt_reg);
                div_neg      = 1'b0;
            end
        endcase
    end

    snrgc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Floor rounding for a negative numerator: -(q + 1) when a remainder is left.
    always_comb
    begin
        fq_mag = div_quo[QW-1:0] + QW'(div_rem != '0);
        fq     = neg_reg ? $signed(-fq_mag) : $signed(div_quo[QW-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            sel_reg <= cmd.div_sel;
            neg_reg <= div_neg;
        end
        if (div_done)
        begin
            unique case (sel_reg)
                snrgc_pkg::DSEL_SX:
                begin
                    sx_ok_reg  <= !neg_reg && (div_quo < NW'(GRID_SIDE));
                    sx_idx_reg <= div_quo[IW-1:0];
                end
                snrgc_pkg::DSEL_SY:
                begin
                    sy_ok_reg  <= !neg_reg && (div_quo < NW'(GRID_SIDE));
                    sy_idx_reg <= div_quo[IW-1:0];
                end
                snrgc_pkg::DSEL_CX:   cx_reg      <= sat_pos(center_x_reg, fq);
                snrgc_pkg::DSEL_CY:   cy_reg      <= sat_pos(center_y_reg, fq);
                snrgc_pkg::DSEL_QUAL: quality_reg <= div_quo[SW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        out_next = '0;
        if (func_reg == snrgc_pkg::FUNC_STORE)
        begin
            out_next.in_map = in_map_reg;
        end
        else if (func_reg == snrgc_pkg::FUNC_COMPUTE)
        begin
            if (max_reg == '0)
            begin
                out_next.centroid_x = center_x_reg;
                out_next.centroid_y = center_y_reg;
            end
            else
            begin
                out_next.found      = 1'b1;
                out_next.centroid_x = cx_reg;
                out_next.centroid_y = cy_reg;
                out_next.quality    = quality_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_data <= out_next;
    end

    assign status.func      = func_reg;
    assign status.addr_last = addr_reg == AW'(N - 1);
    assign status.max_zero  = max_reg == '0;
    assign status.div_done  = div_done;

endmodule
`default_nettype wire

>>> rtl/core/snrgc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SNR grid centroid controller
// Sequences the grid sweeps, weight iterations and divisions for each word.
// ----------------------------------------------------------------------------
module snrgc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  wire logic                out_stall,
    input  wire snrgc_pkg::status_t  status,
    output snrgc_pkg::cmd_t          cmd
);

    localparam logic [4:0] S_INIT_CLR = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_DISP     = 5'd2;
    localparam logic [4:0] S_SXW      = 5'd3;
    localparam logic [4:0] S_SYW      = 5'd4;
    localparam logic [4:0] S_SWR      = 5'd5;
    localparam logic [4:0] S_CLR      = 5'd6;
    localparam logic [4:0] S_MAX_RD   = 5'd7;
    localparam logic [4:0] S_MAX_CMP  = 5'd8;
    localparam logic [4:0] S_MX2      = 5'd9;
    localparam logic [4:0] S_W_RD     = 5'd10;
    localparam logic [4:0] S_W_LD     = 5'd11;
    localparam logic [4:0] S_W_IT     = 5'd12;
    localparam logic [4:0] S_W_ACC    = 5'd13;
    localparam logic [4:0] S_MUL_INIT = 5'd14;
    localparam logic [4:0] S_MUL      = 5'd15;
    localparam logic [4:0] S_CXS      = 5'd16;
    localparam logic [4:0] S_CXW      = 5'd17;
    localparam logic [4:0] S_CYW      = 5'd18;
    localparam logic [4:0] S_QW       = 5'd19;
    localparam logic [4:0] S_DONE     = 5'd20;

    localparam int ITW = 5;

    logic [4:0]     state_reg;
    logic [4:0]     state_next;
    logic [ITW-1:0] iter_reg;
    logic [ITW-1:0] iter_next;
    logic           out_valid_reg;
    logic           out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        cmd        = '0;
        cmd.div_sel = snrgc_pkg::DSEL_SX;
        unique case (state_reg)
            S_INIT_CLR, S_CLR:
            begin
                cmd.mem_clr_we = 1'b1;
                cmd.addr_inc   = 1'b1;
                if (status.addr_last)
                    state_next = (state_reg == S_CLR) ? S_DONE : S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    cmd.addr_clr = 1'b1;
                    state_next   = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (status.func)
                    snrgc_pkg::FUNC_STORE:
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = snrgc_pkg::DSEL_SX;
                        state_next    = S_SXW;
                    end
                    snrgc_pkg::FUNC_CLEAR:   state_next = S_CLR;
                    snrgc_pkg::FUNC_COMPUTE:
                    begin
                        cmd.max_clr = 1'b1;
                        state_next  = S_MAX_RD;
                    end
                    default:                 state_next = S_DONE;
                endcase
            end
            S_SXW:
            begin
                if (status.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = snrgc_pkg::DSEL_SY;
                    state_next    = S_SYW;
                end
            end
            S_SYW:
            begin
                if (status.div_done)
                    state_next = S_SWR;
            end
            S_SWR:
            begin
                cmd.mem_store_we = 1'b1;
                state_next       = S_DONE;
            end
            S_MAX_RD:
            begin
                state_next = S_MAX_CMP;
            end
            S_MAX_CMP:
            begin
                cmd.max_upd  = 1'b1;
                cmd.addr_inc = 1'b1;
                state_next   = status.addr_last ? S_MX2 : S_MAX_RD;
            end
            S_MX2:
            begin
                if (status.max_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.mx2_load = 1'b1;
                    cmd.acc_clr  = 1'b1;
                    cmd.addr_clr = 1'b1;
                    state_next   = S_W_RD;
                end
            end
            S_W_RD:
            begin
                state_next = S_W_LD;
            end
            S_W_LD:
            begin
                cmd.w_init = 1'b1;
                iter_next  = '0;
                state_next = S_W_IT;
            end
            S_W_IT:
            begin
                cmd.w_step = 1'b1;
                iter_next  = iter_reg + 1'b1;
                if (iter_reg == ITW'(snrgc_pkg::W_STEPS - 1))
                    state_next = S_W_ACC;
            end
            S_W_ACC:
            begin
                cmd.acc_upd  = 1'b1;
                cmd.addr_inc = 1'b1;
                state_next   = status.addr_last ? S_MUL_INIT : S_W_RD;
            end
            S_MUL_INIT:
            begin
                cmd.mul_init = 1'b1;
                iter_next    = '0;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                iter_next    = iter_reg + 1'b1;
                if (iter_reg == ITW'(snrgc_pkg::MUL_STEPS - 1))
                    state_next = S_CXS;
            end
            S_CXS:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = snrgc_pkg::DSEL_CX;
                state_next    = S_CXW;
            end
            S_CXW:
            begin
                if (status.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = snrgc_pkg::DSEL_CY;
                    state_next    = S_CYW;
                end
            end
            S_CYW:
            begin
                if (status.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = snrgc_pkg::DSEL_QUAL;
                    state_next    = S_QW;
                end
            end
            S_QW:
            begin
                if (status.div_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT_CLR;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

>>> tb/sv/snr_grid_weighted_centroid_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SNR grid weighted centroid testbench
// Drives store, clear and compute words through the valid/stall channels,
// predicts each output word with a software grid map and compares every
// field. Directed checks cover the empty grid, off-grid stores, unknown
// operations and register extremes; random phases vary sender and receiver
// idling and the register settings.
// ----------------------------------------------------------------------------
module snr_grid_weighted_centroid_top_tb;

    localparam int  SIDE       = snrgc_pkg::GRID_SIDE_DEF;
    localparam int  CELLS      = SIDE * SIDE;
    localparam longint POS_HI  = 8388607;
    localparam longint POS_LO  = -8388608;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [snrgc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [snrgc_pkg::CFG_W-1:0]     cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    snrgc_pkg::in_word_t             in_data;
    logic                            out_valid;
    logic                            out_stall;
    snrgc_pkg::out_word_t            out_data;

    logic [15:0]          grid_snr [CELLS];
    longint               ctr_x;
    longint               ctr_y;
    longint               cell_sz;
    longint               w_thresh;
    snrgc_pkg::out_word_t expected_words [$];
    int                   errors;
    int                   send_idle_pct;
    int                   recv_stall_pct;
    longint               cycles;

    snr_grid_weighted_centroid_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint sat_pos(longint v);
        if (v > POS_HI)
            return POS_HI;
        if (v < POS_LO)
            return POS_LO;
        return v;
    endfunction

    function automatic snrgc_pkg::out_word_t grid_centroid(snrgc_pkg::in_word_t w);
        snrgc_pkg::out_word_t r;
        longint    res;
        longint    ix;
        longint    iy;
        longint    mx;
        longint    wt;
        longint    s;
        longint    bx;
        longint    by;
        longint    wsum;
        longint    qsum;
        longint    cnt;
        longint    half;
        r = '0;
        res = (cell_sz == 0) ? 1 : cell_sz;
        half = (SIDE + 1) / 2;
        case (w.func)
            snrgc_pkg::FUNC_STORE:
            begin
                ix = floor_div(2 * (longint'($signed(w.pos_x)) - ctr_x) + res * (SIDE + 1),
                               2 * res);
                iy = floor_div(2 * (longint'($signed(w.pos_y)) - ctr_y) + res * (SIDE + 1),
                               2 * res);
                if (ix >= 0 && ix < SIDE && iy >= 0 && iy < SIDE)
                begin
                    grid_snr[ix * SIDE + iy] = w.snr_value;
                    r.in_map = 1'b1;
                end
            end
            snrgc_pkg::FUNC_CLEAR:
            begin
                for (int k = 0; k < CELLS; k++)
                    grid_snr[k] = '0;
            end
            snrgc_pkg::FUNC_COMPUTE:
            begin
                mx = 0;
                for (int k = 0; k < CELLS; k++)
                    if (grid_snr[k] > mx)
                        mx = grid_snr[k];
                if (mx == 0)
                begin
                    r.centroid_x = ctr_x[23:0];
                    r.centroid_y = ctr_y[23:0];
                end
                else
                begin
                    bx = 0;
                    by = 0;
                    wsum = 0;
                    qsum = 0;
                    cnt = 0;
                    for (int i = 0; i < SIDE; i++)
                        for (int j = 0; j < SIDE; j++)
                        begin
                            s = grid_snr[i * SIDE + j];
                            wt = ((s * s) << 16) / (mx * mx);
                            if (wt > w_thresh)
                            begin
                                bx += wt * (i - half);
                                by += wt * (j - half);
                                wsum += wt;
                                qsum += s;
                                cnt++;
                            end
                        end
                    r.found = 1'b1;
                    r.centroid_x = 24'(sat_pos(ctr_x + floor_div(2 * bx * res + wsum,
                                                                  2 * wsum)));
                    r.centroid_y = 24'(sat_pos(ctr_y + floor_div(2 * by * res + wsum,
                                                                  2 * wsum)));
                    r.quality = 16'(qsum / cnt);
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("snr_grid_weighted_centroid_top_tb failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        snrgc_pkg::out_word_t e;
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected output word %h", out_data);
                errors++;
            end
            else
            begin
                e = expected_words.pop_front();
                if (out_data.in_map !== e.in_map)
                begin
                    $error("in_map expected %0d actual %0d", e.in_map, out_data.in_map);
                    errors++;
                end
                if (out_data.found !== e.found)
                begin
                    $error("found expected %0d actual %0d", e.found, out_data.found);
                    errors++;
                end
                if (out_data.centroid_x !== e.centroid_x)
                begin
                    $error("centroid_x expected %0d actual %0d", e.centroid_x,
                           out_data.centroid_x);
                    errors++;
                end
                if (out_data.centroid_y !== e.centroid_y)
                begin
                    $error("centroid_y expected %0d actual %0d", e.centroid_y,
                           out_data.centroid_y);
                    errors++;
                end
                if (out_data.quality !== e.quality)
                begin
                    $error("quality expected %0d actual %0d", e.quality, out_data.quality);
                    errors++;
                end
            end
        end
    end

    task automatic send_word(logic [1:0] f, longint px, longint py, logic [15:0] snr);
        snrgc_pkg::in_word_t w;
        w.func = f;
        w.pos_x = px[23:0];
        w.pos_y = py[23:0];
        w.snr_value = snr;
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        expected_words.push_back(grid_centroid(w));
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [snrgc_pkg::CFG_IDX_W-1:0] idx, longint val);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[23:0];
        case (idx)
            snrgc_pkg::CFG_CENTER_X:  ctr_x = longint'($signed(val[23:0]));
            snrgc_pkg::CFG_CENTER_Y:  ctr_y = longint'($signed(val[23:0]));
            snrgc_pkg::CFG_CELL_SIZE: cell_sz = val & 16'hFFFF;
            default:                  w_thresh = val & 16'hFFFF;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic longint near_pos(longint c);
        longint res;
        res = (cell_sz == 0) ? 1 : cell_sz;
        return sat_pos(c + (longint'($urandom_range(0, 35)) - 18) * res
                       + longint'($urandom_range(0, 32'(res - 1))));
    endfunction

    task automatic test_basic_ops();
        send_word(snrgc_pkg::FUNC_COMPUTE, 0, 0, 16'hFFFF);
        send_word(snrgc_pkg::FUNC_STORE, 0, 0, 16'hFFFF);
        send_word(snrgc_pkg::FUNC_STORE, POS_HI, POS_LO, 16'h0000);
        send_word(snrgc_pkg::FUNC_STORE, POS_LO, POS_HI, 16'h5A5A);
        send_word(snrgc_pkg::FUNC_STORE, -4096, 3968, 16'h0001);
        send_word(snrgc_pkg::FUNC_STORE, 3968, -4096, 16'hFFFE);
        send_word(snrgc_pkg::FUNC_STORE, 4096, 0, 16'hE000);
        send_word(FUNC_NONE, POS_HI, POS_HI, 16'hFFFF);
        send_word(snrgc_pkg::FUNC_COMPUTE, 0, 0, 16'h0000);
        send_word(snrgc_pkg::FUNC_CLEAR, 0, 0, 16'h0000);
        send_word(snrgc_pkg::FUNC_COMPUTE, 0, 0, 16'h0000);
    endtask

    task automatic test_register_extremes();
        write_reg(snrgc_pkg::CFG_CELL_SIZE, 0);
        write_reg(snrgc_pkg::CFG_CENTER_X, POS_HI);
        write_reg(snrgc_pkg::CFG_CENTER_Y, POS_LO);
        write_reg(snrgc_pkg::CFG_THRESHOLD, 0);
        send_word(snrgc_pkg::FUNC_STORE, POS_HI, POS_LO, 16'h0100);
        send_word(snrgc_pkg::FUNC_STORE, POS_HI - 15, POS_LO + 15, 16'h0080);
        send_word(snrgc_pkg::FUNC_STORE, POS_HI - 16, POS_LO + 16, 16'hFFFF);
        send_word(snrgc_pkg::FUNC_COMPUTE, 0, 0, 16'h0000);
        write_reg(snrgc_pkg::CFG_CELL_SIZE, 65535);
        write_reg(snrgc_pkg::CFG_CENTER_X, 0);
        write_reg(snrgc_pkg::CFG_CENTER_Y, 0);
        write_reg(snrgc_pkg::CFG_THRESHOLD, 65535);
        send_word(snrgc_pkg::FUNC_STORE, 65535 * 15, -65535 * 16, 16'hFFFF);
        send_word(snrgc_pkg::FUNC_STORE, -65535 * 3, 65535 * 2, 16'hFFFF);
        send_word(snrgc_pkg::FUNC_COMPUTE, 0, 0, 16'h0000);
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        int     r;
        longint px;
        longint py;
        logic [15:0] snr;
        r = $urandom_range(0, 3);
        write_reg(snrgc_pkg::CFG_CELL_SIZE, (r == 0) ? $urandom_range(1, 65535)
                                                     : $urandom_range(1, 1024));
        write_reg(snrgc_pkg::CFG_THRESHOLD, (r == 1) ? $urandom_range(0, 65535)
                                                     : $urandom_range(30000, 65535));
        write_reg(snrgc_pkg::CFG_CENTER_X, (r == 2) ? POS_HI - $urandom_range(0, 1000)
                                                    : $urandom_range(0, 32'hFFFFFF));
        write_reg(snrgc_pkg::CFG_CENTER_Y, (r == 3) ? POS_LO + $urandom_range(0, 1000)
                                                    : $urandom_range(0, 32'hFFFFFF));
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
            begin
                px = longint'($signed(24'($urandom())));
                py = longint'($signed(24'($urandom())));
            end
            else
            begin
                px = near_pos(ctr_x);
                py = near_pos(ctr_y);
            end
            snr = ($urandom_range(0, 1) == 1) ? 16'($urandom())
                                               : 16'(16'hFFFF - $urandom_range(0, 8000));
            if (r < 88)
                send_word(snrgc_pkg::FUNC_STORE, px, py, snr);
            else if (r < 91)
                send_word(snrgc_pkg::FUNC_CLEAR, px, py, snr);
            else if (r < 94)
                send_word(FUNC_NONE, px, py, snr);
            else
                send_word(snrgc_pkg::FUNC_COMPUTE, px, py, snr);
        end
        send_word(snrgc_pkg::FUNC_COMPUTE, 0, 0, 16'h0000);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        ctr_x = 0;
        ctr_y = 0;
        cell_sz = snrgc_pkg::RST_CELL_SIZE;
        w_thresh = snrgc_pkg::RST_THRESHOLD;
        for (int k = 0; k < CELLS; k++)
            grid_snr[k] = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        test_basic_ops();
        test_register_extremes();
        test_random_phase(0, 0, 72);
        test_random_phase(45, 0, 72);
        test_random_phase(0, 45, 72);
        test_random_phase(27, 27, 72);
        wait_idle();
        repeat (50)
            @(posedge clk);
        if (errors == 0 && expected_words.size() == 0)
            $display("snr_grid_weighted_centroid_top_tb passed");
        else
            $display("snr_grid_weighted_centroid_top_tb failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/snrgc_pkg.sv
rtl/core/snrgc_div.sv
rtl/core/snrgc_datapath.sv
rtl/core/snrgc_ctrl.sv
rtl/core/snr_grid_weighted_centroid_top.sv
tb/sv/snr_grid_weighted_centroid_top_tb.sv
